### rtl/core/osen_pkg.sv
// ----------------------------------------------------------------------------
// osen_pkg
// Shared types, codes and helpers of the ordered subset enumerator.
// ----------------------------------------------------------------------------
package osen_pkg;

	localparam int MAX_ENTRIES_DEF = 8;
	localparam int VALUE_SPACE_DEF = 32;

	localparam int REQ_TYPE_W   = 2;
	localparam int READ_IDX_W   = 3;
	localparam int COUNT_W      = 4;
	localparam int ENTRY_W      = 5;
	localparam int MASK_W       = 32;
	localparam int VCOUNT_W     = 6;
	localparam int SLIMIT_W     = 4;
	localparam int CFG_IDX_W    = 1;
	localparam int CFG_DATA_W   = 6;
	localparam int EFF_W        = 7;
	localparam int CAP_W        = 5;

	localparam logic [CFG_IDX_W-1:0] CFG_VALUE_COUNT = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_SIZE_LIMIT  = 1'b1;

	typedef enum logic [REQ_TYPE_W-1:0] {
		REQ_RESTART,
		REQ_STEP,
		REQ_SKIP,
		REQ_READ
	} req_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_POP,
		ST_READ,
		ST_RESP
	} state_t;

	typedef enum logic [2:0] {
		ACT_NONE,
		ACT_RESTART,
		ACT_APPEND,
		ACT_INC,
		ACT_POP
	} act_t;

	typedef struct packed {
		logic fits;
		logic room;
	} alu_flags_t;

	function automatic logic [MASK_W-1:0] mask_bit(input logic [EFF_W-1:0] v);
		logic [MASK_W-1:0] m;
		m = '0;
		if (v < EFF_W'(MASK_W)) begin
			m = MASK_W'(1) << v[4:0];
		end
		return m;
	endfunction

endpackage

### rtl/core/osen_if.sv
// ----------------------------------------------------------------------------
// osen_if
// Request and response channels of the ordered subset enumerator.
// ----------------------------------------------------------------------------
interface osen_req_if;
	logic                             valid;
	logic                             ready;
	logic [osen_pkg::REQ_TYPE_W-1:0]  req_type;
	logic [osen_pkg::READ_IDX_W-1:0]  read_index;

	modport source (output valid, req_type, read_index, input ready);
	modport sink   (input valid, req_type, read_index, output ready);
endinterface

interface osen_rsp_if;
	logic                          valid;
	logic                          ready;
	logic                          advanced;
	logic [osen_pkg::COUNT_W-1:0]  subset_count;
	logic [osen_pkg::ENTRY_W-1:0]  entry_value;
	logic                          entry_valid;
	logic [osen_pkg::MASK_W-1:0]   member_mask;

	modport source (output valid, advanced, subset_count, entry_value, entry_valid,
		member_mask, input ready);
	modport sink   (input valid, advanced, subset_count, entry_value, entry_valid,
		member_mask, output ready);
endinterface

### rtl/core/osen_store.sv
// ----------------------------------------------------------------------------
// osen_store
// Entry memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
module osen_store #(
	parameter int DEPTH = 8,
	parameter int WIDTH = 5,
	parameter int AW    = 3
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

### rtl/core/osen_alu.sv
// ----------------------------------------------------------------------------
// osen_alu
// Shared increment and compare unit: next value, range fit, room to append.
// ----------------------------------------------------------------------------
module osen_alu #(
	parameter int VW = 5,
	parameter int CW = 4
) (
	input  logic [VW-1:0]                 cur,
	input  logic [osen_pkg::EFF_W-1:0]    eff,
	input  logic [CW-1:0]                 live,
	input  logic [osen_pkg::CAP_W-1:0]    cap,
	output logic [VW-1:0]                 nxt,
	output osen_pkg::alu_flags_t          flags
);
	import osen_pkg::*;

	logic [VW:0] sum;

	always_comb begin
		sum        = (VW+1)'(cur) + (VW+1)'(1);
		nxt        = sum[VW-1:0];
		flags.fits = EFF_W'(sum) < eff;
		flags.room = CAP_W'(live) < cap;
	end

endmodule

### rtl/core/ordered_subset_enumerator_core.sv
// Sequence: restart, read and a step or skip that appends or increments pass EXEC, READ
// and RESP, and the result is registered on leaving RESP; each popped entry adds a pass
// through POP, except the pop that empties the subset.
// Requests do not overlap: the sequencer walks EXEC, POP, READ and RESP before it takes
// the next request; a waiting result holds RESP and the input.
// Reset: empty subset, value_count 0, size_limit 1, no result pending; the entry
// store is not cleared.
// ----------------------------------------------------------------------------
// ordered_subset_enumerator_core
// Lexicographic walk over increasing subsets under a small sequencer.
// ----------------------------------------------------------------------------
module ordered_subset_enumerator_core #(
	parameter int MAX_ENTRIES = osen_pkg::MAX_ENTRIES_DEF,
	parameter int VALUE_SPACE = osen_pkg::VALUE_SPACE_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	osen_req_if.sink                           req,
	osen_rsp_if.source                         rsp,
	input  logic                               cfg_wr_en,
	input  logic [osen_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [osen_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import osen_pkg::*;

	localparam int VW = $clog2(VALUE_SPACE);
	localparam int CW = $clog2(MAX_ENTRIES + 1);
	localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

	state_t                state_q, state_d;
	act_t                  act;
	req_t                  req_q;
	logic [READ_IDX_W-1:0] idx_q;
	logic                  ok_q, ok_d;
	logic [CW-1:0]         live_q, live_d;
	logic [MASK_W-1:0]     mask_q, mask_d;
	logic [VCOUNT_W-1:0]   value_count_q;
	logic [SLIMIT_W-1:0]   size_limit_q;

	logic                  out_valid_q;
	logic                  out_adv_q;
	logic [COUNT_W-1:0]    out_count_q;
	logic [ENTRY_W-1:0]    out_value_q;
	logic                  out_evalid_q;
	logic [MASK_W-1:0]     out_mask_q;

	logic                  we;
	logic [AW-1:0]         waddr, raddr;
	logic [VW-1:0]         wdata, rdata, nxt;
	logic [EFF_W-1:0]      eff;
	logic [CAP_W-1:0]      cap;
	alu_flags_t            flags;
	logic                  live_zero, over_limit, restart_ok, out_free, idx_valid;
	act_t                  skip_act;

	osen_store #(.DEPTH(MAX_ENTRIES), .WIDTH(VW), .AW(AW)) u_store (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	osen_alu #(.VW(VW), .CW(CW)) u_alu (
		.cur  (rdata),
		.eff  (eff),
		.live (live_q),
		.cap  (cap),
		.nxt  (nxt),
		.flags(flags)
	);

	always_comb begin
		eff = (EFF_W'(value_count_q) > EFF_W'(VALUE_SPACE)) ? EFF_W'(VALUE_SPACE)
			: EFF_W'(value_count_q);
		cap = (CAP_W'(size_limit_q) > CAP_W'(MAX_ENTRIES)) ? CAP_W'(MAX_ENTRIES)
			: CAP_W'(size_limit_q);
		live_zero  = (live_q == '0);
		over_limit = CAP_W'(live_q) > CAP_W'(size_limit_q);
		restart_ok = (size_limit_q != '0) && (CAP_W'(size_limit_q) <= CAP_W'(MAX_ENTRIES));
		out_free   = !out_valid_q || rsp.ready;
		idx_valid  = CAP_W'(idx_q) < CAP_W'(live_q);
		skip_act   = flags.fits ? ACT_INC : ACT_POP;
	end

	always_comb begin
		act = ACT_NONE;
		case (state_q)
			ST_EXEC: begin
				case (req_q)
					REQ_RESTART: act = restart_ok ? ACT_RESTART : ACT_NONE;
					REQ_STEP: begin
						if (live_zero || over_limit) begin
							act = ACT_NONE;
						end else if (flags.fits && flags.room) begin
							act = ACT_APPEND;
						end else begin
							act = skip_act;
						end
					end
					REQ_SKIP: act = live_zero ? ACT_NONE : skip_act;
					default:  act = ACT_NONE;
				endcase
			end
			ST_POP:  act = skip_act;
			default: act = ACT_NONE;
		endcase
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (req.valid) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC, ST_POP: begin
				if (act == ACT_POP && live_q != CW'(1)) begin
					state_d = ST_POP;
				end else begin
					state_d = ST_READ;
				end
			end
			ST_READ: state_d = ST_RESP;
			ST_RESP: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		we     = 1'b0;
		waddr  = '0;
		wdata  = nxt;
		live_d = live_q;
		mask_d = mask_q;
		ok_d   = act inside {ACT_RESTART, ACT_APPEND, ACT_INC};
		raddr  = AW'(idx_q);
		case (act)
			ACT_RESTART: begin
				we     = 1'b1;
				wdata  = '0;
				live_d = CW'(1);
				mask_d = MASK_W'(1);
			end
			ACT_APPEND: begin
				we     = 1'b1;
				waddr  = AW'(live_q);
				live_d = live_q + CW'(1);
				mask_d = mask_q | mask_bit(EFF_W'(nxt));
			end
			ACT_INC: begin
				we     = 1'b1;
				waddr  = AW'(live_q - CW'(1));
				mask_d = (mask_q & ~mask_bit(EFF_W'(rdata))) | mask_bit(EFF_W'(nxt));
			end
			ACT_POP: begin
				live_d = live_q - CW'(1);
				mask_d = mask_q & ~mask_bit(EFF_W'(rdata));
			end
			default: begin
				we = 1'b0;
			end
		endcase
		case (state_q)
			ST_IDLE:         raddr = AW'(live_q - CW'(1));
			ST_EXEC, ST_POP: raddr = AW'(live_q - CW'(2));
			default:         raddr = AW'(idx_q);
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			live_q        <= '0;
			mask_q        <= '0;
			value_count_q <= '0;
			size_limit_q  <= SLIMIT_W'(1);
			out_valid_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			live_q  <= live_d;
			mask_q  <= mask_d;
			if (cfg_wr_en) begin
				case (cfg_index)
					CFG_VALUE_COUNT: value_count_q <= cfg_data[VCOUNT_W-1:0];
					CFG_SIZE_LIMIT:  size_limit_q  <= cfg_data[SLIMIT_W-1:0];
					default:         value_count_q <= value_count_q;
				endcase
			end
			if (state_q == ST_RESP && out_free) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && req.valid) begin
			req_q <= req_t'(req.req_type);
			idx_q <= req.read_index;
		end
		if (state_q == ST_EXEC || state_q == ST_POP) begin
			ok_q <= ok_d;
		end
		if (state_q == ST_RESP && out_free) begin
			out_adv_q    <= ok_q;
			out_count_q  <= COUNT_W'(live_q);
			out_evalid_q <= idx_valid;
			out_value_q  <= idx_valid ? ENTRY_W'(rdata) : '0;
			out_mask_q   <= mask_q;
		end
	end

	assign req.ready        = (state_q == ST_IDLE);
	assign rsp.valid        = out_valid_q;
	assign rsp.advanced     = out_adv_q;
	assign rsp.subset_count = out_count_q;
	assign rsp.entry_value  = out_value_q;
	assign rsp.entry_valid  = out_evalid_q;
	assign rsp.member_mask  = out_mask_q;

`ifndef SYNTHESIS
	a_live_bound: assert property (@(posedge clk) disable iff (!arst_n)
		CAP_W'(live_q) <= CAP_W'(MAX_ENTRIES))
		else $error("subset size above store depth");

	a_mask_matches: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE && VALUE_SPACE <= MASK_W) |-> $countones(mask_q) == int'(live_q))
		else $error("member mask out of step with subset size");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_POP |-> live_q != '0)
		else $error("pop on empty subset");

	a_adv_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.advanced) |-> rsp.subset_count != '0)
		else $error("successful request left an empty subset");
`endif

endmodule
